// ===== hdl/pmc_pkg.sv =====
package pmc_pkg;

    // Fraction bits of the base-2 log (one squaring stage per bit)
    localparam int LOG_TABLE_BITS = 8;

    // Magnitude and leading-one exponent
    localparam int V_W = 16;
    localparam int E_W = 4;

    // Signed 10*log2 value, fraction LOG_TABLE_BITS bits
    localparam int LOG_L_W = E_W + LOG_TABLE_BITS + 5;

    // Common scaling of log value against scale_max (ratio is scale free)
    localparam int LX_SH = (LOG_TABLE_BITS > 8) ? 0 : 8 - LOG_TABLE_BITS;
    localparam int LM_SH = (LOG_TABLE_BITS > 8) ? LOG_TABLE_BITS - 8 : 0;

    // Mapped value, maximum, ramp operands, divider operands
    localparam int X_W = (LOG_L_W - 1 + LX_SH > V_W) ? LOG_L_W - 1 + LX_SH : V_W;
    localparam int M_W = 16 + LM_SH;
    localparam int A_W = X_W + 3;
    localparam int D_W = M_W + 2;
    localparam int P_W = (A_W > D_W) ? A_W : D_W;
    localparam int Q_W = D_W;
    localparam int N_W = P_W + 10;

    // Divider: one set-up stage, then two quotient bits per stage
    localparam int DIV_STAGES   = 4;
    localparam int DIV_BITS_PER = 2;
    localparam int DIV_Q_W      = DIV_STAGES * DIV_BITS_PER;
    localparam int DIV_LAT      = DIV_STAGES + 1;

    // Hue wheel: 36 steps per unit, reduced mod 360 by reciprocal multiply
    localparam int HUE_H_W = 22;
    localparam int HUE_Q_W = 14;
    localparam int HUE_SH  = 30;
    localparam int HUE_K   = (1 << HUE_SH) / 360;
    localparam int HUE_LAT = 4;
    localparam int HUE_PAD = LOG_TABLE_BITS - HUE_LAT;

    // Register map (word address bit)
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    typedef enum logic [2:0] {
        MODE_BLUE     = 3'd0,
        MODE_HOT      = 3'd1,
        MODE_GRAY     = 3'd2,
        MODE_LOG_BLUE = 3'd3,
        MODE_LOG_HOT  = 3'd4,
        MODE_LOG_GRAY = 3'd5,
        MODE_HUE      = 3'd6,
        MODE_BLUE_ALT = 3'd7
    } cmap_mode_t;

    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_FULL  = 2'd1,
        SEL_RATIO = 2'd2
    } chan_sel_t;

    typedef struct packed {
        logic      last;
        chan_sel_t sel_r;
        chan_sel_t sel_g;
        chan_sel_t sel_b;
    } pmc_side_t;

endpackage

// ===== hdl/pmc_log.sv =====
module pmc_log
    import pmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      advance,
    input  logic [E_W-1:0]            e_in,
    input  logic [V_W-1:0]            m_in,
    output logic [E_W-1:0]            e_out,
    output logic [LOG_TABLE_BITS-1:0] f_out
);

    logic [V_W-1:0]            m_reg  [LOG_TABLE_BITS];
    logic [V_W-1:0]            m_next [LOG_TABLE_BITS];
    logic [LOG_TABLE_BITS-1:0] f_reg  [LOG_TABLE_BITS];
    logic [LOG_TABLE_BITS-1:0] f_next [LOG_TABLE_BITS];
    logic [E_W-1:0]            e_reg  [LOG_TABLE_BITS];
    logic [E_W-1:0]            e_next [LOG_TABLE_BITS];

    // One squaring of the mantissa per stage, one fraction bit out
    for (genvar k = 0; k < LOG_TABLE_BITS; k++)
    begin : g_sq
        logic [V_W-1:0]            m_src;
        logic [LOG_TABLE_BITS-1:0] f_src;
        logic [E_W-1:0]            e_src;
        logic [2*V_W-1:0]          sq;
        logic [V_W:0]              sq_sh;

        if (k == 0)
        begin : g_first
            assign m_src = m_in;
            assign f_src = '0;
            assign e_src = e_in;
        end
        else
        begin : g_rest
            assign m_src = m_reg[k-1];
            assign f_src = f_reg[k-1];
            assign e_src = e_reg[k-1];
        end

        assign sq        = m_src * m_src;
        assign sq_sh     = sq[2*V_W-1:V_W-1];
        assign m_next[k] = sq_sh[V_W] ? sq_sh[V_W:1] : sq_sh[V_W-1:0];
        assign f_next[k] = {f_src[LOG_TABLE_BITS-2:0], sq_sh[V_W]};
        assign e_next[k] = e_src;

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                m_reg[k] <= m_next[k];
                f_reg[k] <= f_next[k];
                e_reg[k] <= e_next[k];
            end
        end
    end

    assign e_out = e_reg[LOG_TABLE_BITS-1];
    assign f_out = f_reg[LOG_TABLE_BITS-1];

endmodule

// ===== hdl/pmc_hue.sv =====
module pmc_hue
    import pmc_pkg::*;
(
    input  logic        clk,
    input  logic        advance,
    input  logic [31:0] prod_in,
    output logic [2:0]  sec_out,
    output logic [5:0]  rem_out
);

    logic [HUE_H_W-1:0]   h1_reg, h1_next;
    logic [HUE_H_W-1:0]   h2_reg;
    logic [HUE_Q_W-1:0]   hq2_reg, hq2_next;
    logic [8:0]           hm3_reg, hm3_next;
    logic [2:0]           sec4_reg, sec4_next;
    logic [5:0]           rem4_reg, rem4_next;
    logic [37:0]          prod36;
    logic [2*HUE_H_W-1:0] qmul;
    logic [HUE_H_W-1:0]   hsub;
    logic [8:0]           rem9;

    // Stage 1: scale by 36, drop 16 fraction bits
    assign prod36  = {6'b0, prod_in} * 38'd36;
    assign h1_next = prod36[16 +: HUE_H_W];

    // Stage 2: quotient estimate by 360 (exact or one short)
    assign qmul     = {{HUE_H_W{1'b0}}, h1_reg} * (2*HUE_H_W)'(HUE_K);
    assign hq2_next = qmul[HUE_SH +: HUE_Q_W];

    // Stage 3: remainder with one correction step
    assign hsub     = h2_reg - (HUE_H_W'(hq2_reg) * HUE_H_W'(360));
    assign hm3_next = (hsub[9:0] >= 10'd360) ? 9'(hsub[9:0] - 10'd360) : hsub[8:0];

    // Stage 4: sector and position within sector
    always_comb
    begin
        priority if (hm3_reg >= 9'd300) sec4_next = 3'd5;
        else if (hm3_reg >= 9'd240)     sec4_next = 3'd4;
        else if (hm3_reg >= 9'd180)     sec4_next = 3'd3;
        else if (hm3_reg >= 9'd120)     sec4_next = 3'd2;
        else if (hm3_reg >= 9'd60)      sec4_next = 3'd1;
        else                            sec4_next = 3'd0;
        rem9      = hm3_reg - (9'(sec4_next) * 9'd60);
        rem4_next = rem9[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h1_reg   <= h1_next;
            h2_reg   <= h1_reg;
            hq2_reg  <= hq2_next;
            hm3_reg  <= hm3_next;
            sec4_reg <= sec4_next;
            rem4_reg <= rem4_next;
        end
    end

    // Pad to the latency of the log unit
    if (HUE_PAD > 0)
    begin : g_pad
        logic [2:0] sec_pad_reg [HUE_PAD];
        logic [5:0] rem_pad_reg [HUE_PAD];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sec_pad_reg[0] <= sec4_reg;
                rem_pad_reg[0] <= rem4_reg;
                for (int i = 1; i < HUE_PAD; i++)
                begin
                    sec_pad_reg[i] <= sec_pad_reg[i-1];
                    rem_pad_reg[i] <= rem_pad_reg[i-1];
                end
            end
        end

        assign sec_out = sec_pad_reg[HUE_PAD-1];
        assign rem_out = rem_pad_reg[HUE_PAD-1];
    end
    else
    begin : g_nopad
        assign sec_out = sec4_reg;
        assign rem_out = rem4_reg;
    end

endmodule

// ===== hdl/pmc_div.sv =====
module pmc_div
    import pmc_pkg::*;
(
    input  logic           clk,
    input  logic           advance,
    input  logic [P_W-1:0] p_in,
    input  logic [Q_W-1:0] q_in,
    output logic [7:0]     ratio_out
);

    // Rounded 255*p/q: quotient of (510p + q) / 2q, 0 for p = 0, 255 for p >= q
    logic [N_W-1:0]     rem_reg  [DIV_LAT];
    logic [N_W-1:0]     rem_next [DIV_LAT];
    logic [DIV_Q_W-1:0] quot_reg [DIV_LAT];
    logic [DIV_Q_W-1:0] quot_next[DIV_LAT];
    logic [Q_W:0]       d_reg    [DIV_LAT];
    logic               zero_reg [DIV_LAT];
    logic               sat_reg  [DIV_LAT];
    logic [Q_W:0]       d_next;
    logic               zero_next;
    logic               sat_next;

    // Set-up stage
    assign rem_next[0]  = (N_W'(p_in) * N_W'(510)) + N_W'(q_in);
    assign quot_next[0] = '0;
    assign d_next       = {q_in, 1'b0};
    assign zero_next    = (p_in == '0);
    assign sat_next     = (P_W'(p_in) >= P_W'(q_in));

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= rem_next[0];
            quot_reg[0] <= quot_next[0];
            d_reg[0]    <= d_next;
            zero_reg[0] <= zero_next;
            sat_reg[0]  <= sat_next;
        end
    end

    // Restoring stages, two quotient bits each
    for (genvar s = 1; s < DIV_LAT; s++)
    begin : g_st
        localparam int BASE = DIV_Q_W - 1 - DIV_BITS_PER * (s - 1);

        always_comb
        begin
            rem_next[s]  = rem_reg[s-1];
            quot_next[s] = quot_reg[s-1];
            for (int j = 0; j < DIV_BITS_PER; j++)
            begin
                if (rem_next[s] >= (N_W'(d_reg[s-1]) << (BASE - j)))
                begin
                    rem_next[s]             = rem_next[s] - (N_W'(d_reg[s-1]) << (BASE - j));
                    quot_next[s][BASE - j]  = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
                d_reg[s]    <= d_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                sat_reg[s]  <= sat_reg[s-1];
            end
        end
    end

    always_comb
    begin
        priority if (zero_reg[DIV_LAT-1]) ratio_out = 8'd0;
        else if (sat_reg[DIV_LAT-1])      ratio_out = 8'd255;
        else                              ratio_out = quot_reg[DIV_LAT-1][7:0];
    end

endmodule

// ===== hdl/pixel_magnitude_colormap.sv =====
// Channel   Dir  Payload
// s_*       in   tdata[15:0] distance (signed Q8.8), tlast last_pixel
// m_*       out  tdata red[7:0] green[15:8] blue[23:16], tlast last_pixel_out
// APB       in   0x0 colormap_mode[2:0], 0x4 scale_max[15:0]
//
// One pixel per clock while m_tready does not stall; 18 register stages, mostly
// in the log squaring chain (one stage per fraction bit) and the ratio divider
// (set-up plus four quotient stages).
// Reset clears valid bits and loads mode 0, scale_max 1280.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
module pixel_magnitude_colormap
    import pmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // distance[15:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = P_W + 1;

    // Configuration
    cmap_mode_t  mode_reg, mode_next;
    logic [15:0] scale_reg, scale_next;
    logic [15:0] mx;
    logic        cfg_wr;

    logic        advance;

    // Front stages
    logic           vld1_reg, vld1_next;
    logic [V_W-1:0] v1_reg, v1_next;
    logic           last1_reg;
    logic           vld2_reg;
    logic [E_W-1:0] e2_reg, e2_next;
    logic [V_W-1:0] mn2_reg, mn2_next;
    logic [31:0]    prod2_reg, prod2_next;
    logic [V_W-1:0] v2_reg;
    logic           last2_reg;

    // Alongside log and hue units
    logic           vld_d_reg  [LOG_TABLE_BITS];
    logic [V_W-1:0] v_d_reg    [LOG_TABLE_BITS];
    logic           last_d_reg [LOG_TABLE_BITS];

    logic [E_W-1:0]            log_e;
    logic [LOG_TABLE_BITS-1:0] log_f;
    logic [2:0]                hue_sec;
    logic [5:0]                hue_rem;

    // Mapped value stage
    logic signed [LOG_L_W-1:0] lt, l10;
    logic                      is_log;
    logic           vld11_reg;
    logic [X_W-1:0] x11_reg, x11_next;
    logic [M_W-1:0] m11_reg, m11_next;
    logic           last11_reg;
    logic [2:0]     sec11_reg;
    logic [5:0]     rem11_reg;

    // Ratio operand stage
    logic [CW-1:0]  a_c, d_c, d2_c, pr;
    chan_sel_t      rs, gs, bs;
    logic           vld12_reg;
    logic [P_W-1:0] p12_reg, p12_next;
    logic [Q_W-1:0] q12_reg, q12_next;
    pmc_side_t      side12_reg, side12_next;

    // Alongside divider
    logic           vld_dd_reg  [DIV_LAT];
    pmc_side_t      side_dd_reg [DIV_LAT];
    logic [7:0]     ratio;

    // Output register
    logic           m_tvalid_reg;
    logic [23:0]    m_tdata_reg, m_tdata_next;
    logic           m_tlast_reg;

    function automatic logic [7:0] chan_val(chan_sel_t s, logic [7:0] r);
        logic [7:0] o;
        unique case (s)
            SEL_ZERO:  o = 8'd0;
            SEL_FULL:  o = 8'd255;
            SEL_RATIO: o = r;
            default:   o = 8'd0;
        endcase
        return o;
    endfunction

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        mode_next  = mode_reg;
        scale_next = scale_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_MODE)
                mode_next = cmap_mode_t'(pwdata[2:0]);
            else
                scale_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BLUE;
            scale_reg <= 16'd1280;
        end
        else
        begin
            mode_reg  <= mode_next;
            scale_reg <= scale_next;
        end
    end

    assign prdata = (paddr[2] == REG_SCALE) ? {16'b0, scale_reg} : {29'b0, mode_reg};
    assign mx     = (scale_reg == 16'd0) ? 16'd1 : scale_reg;

    // Pipeline moves as one
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Stage 1: magnitude
    assign vld1_next = s_tvalid;
    assign v1_next   = s_tdata[15] ? 16'(~s_tdata + 16'd1) : s_tdata;

    // Stage 2: leading one, normalised mantissa, hue product
    always_comb
    begin
        e2_next = '0;
        for (int i = 1; i < V_W; i++)
        begin
            if (v1_reg[i])
                e2_next = E_W'(i);
        end
        mn2_next   = v1_reg << (E_W'(V_W - 1) - e2_next);
        prod2_next = 32'(v1_reg) * 32'(mx);
    end

    pmc_log u_log (
        .clk     (clk),
        .advance (advance),
        .e_in    (e2_reg),
        .m_in    (mn2_reg),
        .e_out   (log_e),
        .f_out   (log_f)
    );

    pmc_hue u_hue (
        .clk     (clk),
        .advance (advance),
        .prod_in (prod2_reg),
        .sec_out (hue_sec),
        .rem_out (hue_rem)
    );

    // Stage 11: value fed to the map, linear or 10*log2
    always_comb
    begin
        is_log = (mode_reg == MODE_LOG_BLUE) || (mode_reg == MODE_LOG_HOT) ||
                 (mode_reg == MODE_LOG_GRAY);
        lt  = LOG_L_W'({log_e, log_f}) - LOG_L_W'(32'(8) << LOG_TABLE_BITS);
        l10 = (lt <<< 3) + (lt <<< 1);
        if (is_log)
        begin
            if ((v_d_reg[LOG_TABLE_BITS-1] == '0) || l10[LOG_L_W-1])
                x11_next = '0;
            else
                x11_next = X_W'(l10[LOG_L_W-2:0]) << LX_SH;
            m11_next = M_W'(mx) << LM_SH;
        end
        else
        begin
            x11_next = X_W'(v_d_reg[LOG_TABLE_BITS-1]);
            m11_next = M_W'(mx);
        end
    end

    // Stage 12: pick the one ratio this pixel needs, and how channels use it
    always_comb
    begin
        a_c  = CW'(x11_reg) << 3;
        d_c  = CW'(m11_reg) + (CW'(m11_reg) << 1);
        d2_c = d_c << 1;

        if (a_c < d_c)
        begin
            pr = a_c;
            rs = SEL_ZERO; gs = SEL_ZERO; bs = SEL_RATIO;
        end
        else if (a_c <= d2_c)
        begin
            pr = a_c - d_c;
            rs = SEL_ZERO; gs = SEL_RATIO; bs = SEL_FULL;
        end
        else
        begin
            pr = a_c - d2_c;
            rs = SEL_RATIO; gs = SEL_FULL; bs = SEL_FULL;
        end

        p12_next         = P_W'(pr);
        q12_next         = Q_W'(d_c);
        side12_next.last = last11_reg;
        side12_next.sel_r = rs;
        side12_next.sel_g = gs;
        side12_next.sel_b = bs;

        unique case (mode_reg)
            MODE_BLUE, MODE_LOG_BLUE, MODE_BLUE_ALT:
            begin
            end
            MODE_HOT, MODE_LOG_HOT:
            begin
                side12_next.sel_r = bs;
                side12_next.sel_b = rs;
            end
            MODE_GRAY, MODE_LOG_GRAY:
            begin
                p12_next          = P_W'(x11_reg);
                q12_next          = Q_W'(m11_reg);
                side12_next.sel_r = SEL_RATIO;
                side12_next.sel_g = SEL_RATIO;
                side12_next.sel_b = SEL_RATIO;
            end
            MODE_HUE:
            begin
                q12_next = Q_W'(60);
                // rising channel in even sectors, falling in odd ones
                if (sec11_reg[0])
                    p12_next = P_W'(6'd60 - rem11_reg);
                else
                    p12_next = P_W'(rem11_reg);
                unique case (sec11_reg)
                    3'd0:
                    begin
                        side12_next.sel_r = SEL_FULL;
                        side12_next.sel_g = SEL_RATIO;
                        side12_next.sel_b = SEL_ZERO;
                    end
                    3'd1:
                    begin
                        side12_next.sel_r = SEL_RATIO;
                        side12_next.sel_g = SEL_FULL;
                        side12_next.sel_b = SEL_ZERO;
                    end
                    3'd2:
                    begin
                        side12_next.sel_r = SEL_ZERO;
                        side12_next.sel_g = SEL_FULL;
                        side12_next.sel_b = SEL_RATIO;
                    end
                    3'd3:
                    begin
                        side12_next.sel_r = SEL_ZERO;
                        side12_next.sel_g = SEL_RATIO;
                        side12_next.sel_b = SEL_FULL;
                    end
                    3'd4:
                    begin
                        side12_next.sel_r = SEL_RATIO;
                        side12_next.sel_g = SEL_ZERO;
                        side12_next.sel_b = SEL_FULL;
                    end
                    default:
                    begin
                        side12_next.sel_r = SEL_FULL;
                        side12_next.sel_g = SEL_ZERO;
                        side12_next.sel_b = SEL_RATIO;
                    end
                endcase
            end
        endcase
    end

    pmc_div u_div (
        .clk       (clk),
        .advance   (advance),
        .p_in      (p12_reg),
        .q_in      (q12_reg),
        .ratio_out (ratio)
    );

    // Output colour
    assign m_tdata_next = {chan_val(side_dd_reg[DIV_LAT-1].sel_b, ratio),
                           chan_val(side_dd_reg[DIV_LAT-1].sel_g, ratio),
                           chan_val(side_dd_reg[DIV_LAT-1].sel_r, ratio)};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            vld11_reg    <= 1'b0;
            vld12_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LOG_TABLE_BITS; i++)
                vld_d_reg[i] <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
                vld_dd_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            vld1_reg     <= vld1_next;
            vld2_reg     <= vld1_reg;
            vld_d_reg[0] <= vld2_reg;
            for (int i = 1; i < LOG_TABLE_BITS; i++)
                vld_d_reg[i] <= vld_d_reg[i-1];
            vld11_reg     <= vld_d_reg[LOG_TABLE_BITS-1];
            vld12_reg     <= vld11_reg;
            vld_dd_reg[0] <= vld12_reg;
            for (int i = 1; i < DIV_LAT; i++)
                vld_dd_reg[i] <= vld_dd_reg[i-1];
            m_tvalid_reg <= vld_dd_reg[DIV_LAT-1];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v1_reg    <= v1_next;
            last1_reg <= s_tlast;
            e2_reg    <= e2_next;
            mn2_reg   <= mn2_next;
            prod2_reg <= prod2_next;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            v_d_reg[0]    <= v2_reg;
            last_d_reg[0] <= last2_reg;
            for (int i = 1; i < LOG_TABLE_BITS; i++)
            begin
                v_d_reg[i]    <= v_d_reg[i-1];
                last_d_reg[i] <= last_d_reg[i-1];
            end
            x11_reg    <= x11_next;
            m11_reg    <= m11_next;
            last11_reg <= last_d_reg[LOG_TABLE_BITS-1];
            sec11_reg  <= hue_sec;
            rem11_reg  <= hue_rem;
            p12_reg    <= p12_next;
            q12_reg    <= q12_next;
            side12_reg <= side12_next;
            side_dd_reg[0] <= side12_reg;
            for (int i = 1; i < DIV_LAT; i++)
                side_dd_reg[i] <= side_dd_reg[i-1];
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= side_dd_reg[DIV_LAT-1].last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_stage1_load: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(advance) |-> vld1_reg == $past(s_tvalid))
        else $error("stage 1 valid does not follow an accepted request");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && !$past(advance) |->
            $stable(p12_reg) && $stable(q12_reg) && $stable(side12_reg) &&
            vld12_reg == $past(vld12_reg))
        else $error("divider operands moved during a stall");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $rose(m_tvalid_reg) |-> $past(vld_dd_reg[DIV_LAT-1]))
        else $error("result appeared with no request behind it");
`endif

endmodule

// ===== dv/tb_pixel_magnitude_colormap.sv =====
`timescale 1ns / 100ps

module tb_pixel_magnitude_colormap;
    import pmc_pkg::*;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } colour_t;

    // directed stimulus row: known colour only where it is obvious
    typedef struct {
        cmap_mode_t  mode;
        logic [15:0] smax;
        logic [15:0] sample;
        logic        last;
        logic        known;
        logic [23:0] rgb;
    } pix_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_magnitude_colormap uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cmap_mode_t  cur_mode;
    logic [15:0] cur_max;
    colour_t     colour_q[$];
    int          n_err;
    int          idle_pct;
    int          stall_pct;
    int          quiet;

    function automatic logic [7:0] scale255(longint p, longint q);
        longint r;
        if (p <= 0 || q <= 0)
            return 8'd0;
        if (p >= q)
            return 8'd255;
        r = (510 * p + q) / (2 * q);
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic void ramp_rgb(longint x, longint m, output logic [7:0] r,
                                     output logic [7:0] g, output logic [7:0] b);
        longint a;
        longint d;
        a = 8 * x;
        d = 3 * m;
        b = (a < d) ? scale255(a, d) : 8'd255;
        g = (a < d) ? 8'd0 : (a > 2 * d) ? 8'd255 : scale255(a - d, d);
        r = (a < 2 * d) ? 8'd0 : scale255(a - 2 * d, d);
    endfunction

    // 10*log2(v/256) with LOG_TABLE_BITS fraction bits, v nonzero
    function automatic longint log10x(int unsigned v);
        int          e;
        longint unsigned mant;
        longint      f;
        e = 15;
        f = 0;
        while (e > 0 && v[e] == 1'b0)
            e--;
        mant = longint'(v) << (15 - e);
        for (int i = 0; i < LOG_TABLE_BITS; i++)
        begin
            mant = (mant * mant) >> 15;
            f = f * 2;
            if (mant >= 65536)
            begin
                f = f + 1;
                mant = mant >> 1;
            end
        end
        return 10 * ((longint'(e) - 8) * (longint'(1) << LOG_TABLE_BITS) + f);
    endfunction

    function automatic colour_t map_pixel(logic [15:0] sample, logic last);
        colour_t     c;
        int unsigned v;
        int unsigned mx;
        longint      lx;
        longint      lm;
        longint unsigned h;
        logic [7:0]  t;
        logic [7:0]  up;
        logic [7:0]  dn;
        v = sample[15] ? (32'h10000 - sample) : sample;
        mx = (cur_max == 0) ? 1 : cur_max;
        lx = (v != 0) ? log10x(v) * 256 : 0;
        lm = longint'(mx) << LOG_TABLE_BITS;
        c.red = 0;
        c.green = 0;
        c.blue = 0;
        c.last = last;
        case (cur_mode)
            MODE_HOT:
            begin
                ramp_rgb(v, mx, c.red, c.green, c.blue);
                t = c.red; c.red = c.blue; c.blue = t;
            end
            MODE_GRAY:
            begin
                c.red = scale255(v, mx); c.green = c.red; c.blue = c.red;
            end
            MODE_LOG_BLUE:
                if (v != 0) ramp_rgb(lx, lm, c.red, c.green, c.blue);
            MODE_LOG_HOT:
                if (v != 0)
                begin
                    ramp_rgb(lx, lm, c.red, c.green, c.blue);
                    t = c.red; c.red = c.blue; c.blue = t;
                end
            MODE_LOG_GRAY:
                if (v != 0)
                begin
                    c.red = scale255(lx, lm); c.green = c.red; c.blue = c.red;
                end
            MODE_HUE:
            begin
                h = ((longint'(v) * mx * 36) >> 16) % 360;
                up = scale255(h % 60, 60);
                dn = scale255(60 - (h % 60), 60);
                case (h / 60)
                    0: begin c.red = 255; c.green = up;  c.blue = 0;   end
                    1: begin c.red = dn;  c.green = 255; c.blue = 0;   end
                    2: begin c.red = 0;   c.green = 255; c.blue = up;  end
                    3: begin c.red = 0;   c.green = dn;  c.blue = 255; end
                    4: begin c.red = up;  c.green = 0;   c.blue = 255; end
                    default: begin c.red = 255; c.green = 0; c.blue = dn; end
                endcase
            end
            default:
                ramp_rgb(v, mx, c.red, c.green, c.blue);
        endcase
        return c;
    endfunction

    // register write: setup then access, only while idle
    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0)
            cur_mode = cmap_mode_t'(val[2:0]);
        else
            cur_max = val[15:0];
    endtask

    task automatic set_map(cmap_mode_t mode, logic [15:0] smax);
        if (mode != cur_mode) reg_write(3'd0, 32'(mode));
        if (smax != cur_max) reg_write(3'd4, 32'(smax));
    endtask

    task automatic drain;
        while (colour_q.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // one request on the slave side, with random sender gaps
    task automatic send_pixel(logic [15:0] sample, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        s_tlast <= last;
        colour_q.push_back(map_pixel(sample, last));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic end_burst;
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= stall_pct);

    // output checking against the oldest expectation
    always @(posedge clk)
    begin
        colour_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (colour_q.size() == 0)
            begin
                $error("unexpected colour %h", m_tdata);
                n_err++;
            end
            else
            begin
                e = colour_q.pop_front();
                if (m_tdata[7:0] !== e.red)
                begin
                    $error("red: expected %0d actual %0d", e.red, m_tdata[7:0]);
                    n_err++;
                end
                if (m_tdata[15:8] !== e.green)
                begin
                    $error("green: expected %0d actual %0d", e.green, m_tdata[15:8]);
                    n_err++;
                end
                if (m_tdata[23:16] !== e.blue)
                begin
                    $error("blue: expected %0d actual %0d", e.blue, m_tdata[23:16]);
                    n_err++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_pixel_out: expected %0d actual %0d", e.last, m_tlast);
                    n_err++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    pix_row_t dir_tab[] = '{
        '{MODE_BLUE,     16'd1280,  16'h0000, 1'b0, 1'b1, 24'h000000},
        '{MODE_BLUE,     16'd1280,  16'h7FFF, 1'b1, 1'b1, 24'hFFFFFF},
        '{MODE_BLUE,     16'd1280,  16'h8000, 1'b0, 1'b1, 24'hFFFFFF},
        '{MODE_BLUE,     16'd1280,  16'h8001, 1'b1, 1'b0, 24'h0},
        '{MODE_BLUE,     16'd1280,  16'hFE00, 1'b0, 1'b0, 24'h0},
        '{MODE_HOT,      16'd1280,  16'h0000, 1'b0, 1'b1, 24'h000000},
        '{MODE_HOT,      16'd1280,  16'h7FFF, 1'b0, 1'b1, 24'hFFFFFF},
        '{MODE_GRAY,     16'd1280,  16'h0000, 1'b1, 1'b1, 24'h000000},
        '{MODE_GRAY,     16'd1280,  16'h8000, 1'b0, 1'b1, 24'hFFFFFF},
        '{MODE_GRAY,     16'd65535, 16'h4000, 1'b0, 1'b0, 24'h0},
        '{MODE_LOG_BLUE, 16'd65535, 16'h0000, 1'b0, 1'b1, 24'h000000},
        '{MODE_LOG_BLUE, 16'd65535, 16'h0080, 1'b0, 1'b1, 24'h000000},
        '{MODE_LOG_BLUE, 16'd1,     16'h1234, 1'b1, 1'b0, 24'h0},
        '{MODE_LOG_HOT,  16'd1,     16'h0000, 1'b0, 1'b1, 24'h000000},
        '{MODE_LOG_HOT,  16'd1,     16'h7FFF, 1'b0, 1'b0, 24'h0},
        '{MODE_LOG_GRAY, 16'd1,     16'h0000, 1'b0, 1'b1, 24'h000000},
        '{MODE_LOG_GRAY, 16'd1,     16'h00FF, 1'b0, 1'b1, 24'h000000},
        '{MODE_LOG_GRAY, 16'd1,     16'h8000, 1'b1, 1'b0, 24'h0},
        '{MODE_HUE,      16'd1280,  16'h0000, 1'b0, 1'b1, 24'h0000FF},
        '{MODE_HUE,      16'd65535, 16'h7FFF, 1'b0, 1'b0, 24'h0},
        '{MODE_HUE,      16'd0,     16'h8000, 1'b1, 1'b0, 24'h0},
        '{MODE_BLUE_ALT, 16'd0,     16'h0001, 1'b0, 1'b0, 24'h0},
        '{MODE_BLUE_ALT, 16'd65535, 16'hFFFF, 1'b1, 1'b0, 24'h0}
    };

    initial
    begin
        colour_t c;
        int      ph;
        int      k;
        cur_mode = MODE_BLUE;
        cur_max = 16'd1280;
        n_err = 0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, one pixel per row with idle in between
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].mode != cur_mode || dir_tab[i].smax != cur_max)
                drain();
            set_map(dir_tab[i].mode, dir_tab[i].smax);
            if (dir_tab[i].known)
            begin
                c = map_pixel(dir_tab[i].sample, dir_tab[i].last);
                if ({c.blue, c.green, c.red} !== dir_tab[i].rgb)
                begin
                    $error("table row %0d: expected %h predicted %h", i,
                           dir_tab[i].rgb, {c.blue, c.green, c.red});
                    n_err++;
                end
            end
            send_pixel(dir_tab[i].sample, dir_tab[i].last);
            end_burst();
        end
        drain();

        // random bursts over settings and idling phases
        for (ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            k = $urandom_range(3);
            set_map(cmap_mode_t'($urandom_range(7)),
                    (k == 0) ? 16'(1 + $urandom_range(3) * 21845)
                             : (k == 1) ? 16'($urandom_range(4096))
                                        : 16'($urandom));
            for (int j = 0; j < 28; j++)
            begin
                k = $urandom_range(3);
                send_pixel((k == 0) ? 16'($urandom_range(2047)) - 16'd1024
                                    : 16'($urandom), 1'($urandom));
            end
            end_burst();
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pmc_pkg.sv
hdl/pmc_log.sv
hdl/pmc_hue.sv
hdl/pmc_div.sv
hdl/pixel_magnitude_colormap.sv
dv/tb_pixel_magnitude_colormap.sv
